FILE: src/log_stream_demux_ansi_strip_core_defines.svh
// Assertion macros shared by the log stream demux checker.
// No dependencies.
`ifndef LOG_STREAM_DEMUX_ANSI_STRIP_CORE_DEFINES_SVH
`define LOG_STREAM_DEMUX_ANSI_STRIP_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LSDAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LSDAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lsdas_pkg.sv
// Types, codes and helpers for the log stream demux / ANSI strip core.
// No dependencies; used by the core and its checker.
package lsdas_pkg;

    // token kinds
    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_LINE  = 3'd1;
    localparam logic [2:0] KIND_PROV  = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    // configuration register indexes
    localparam logic CFG_TTY_MODE    = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0010_0000;
    localparam logic [31:0] SAT32           = 32'hFFFF_FFFF;

    // character codes
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

    // frame header
    localparam logic [7:0] HDR_STDOUT    = 8'h01;
    localparam logic [7:0] HDR_STDERR    = 8'h02;
    localparam logic [2:0] HDR_LEN_FIRST = 3'd4;
    localparam logic [2:0] HDR_LAST      = 3'd7;
    localparam logic [31:0] HDR_BYTES    = 32'd8;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;
    localparam int MAX_RES    = 2;

    typedef enum logic [4:0] {
        ESC_TEXT    = 5'b00001,
        ESC_SEEN    = 5'b00010,
        ESC_CSI     = 5'b00100,
        ESC_OSC     = 5'b01000,
        ESC_OSC_ESC = 5'b10000
    } t_esc;

    typedef struct packed {
        logic [2:0] kind;
        logic       sid;
        logic [7:0] chr;
    } t_tok;

    typedef struct packed {
        t_tok        tok;
        logic [31:0] total;
        logic        last;
    } t_res;

    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        return (a == SAT32) ? SAT32 : a + 32'd1;
    endfunction

endpackage

FILE: src/log_stream_demux_ansi_strip_core.sv
// A word's results are written into the registered result queue when it is accepted, behind any held results.
// Throughput: one input word per cycle while each word yields at most one result and the master
// side is not stalled; a word with two results is absorbed by the 4-entry result queue.
// s_axis_tready depends only on queue fill (room for two results).
// Reset (i_rst_n low, synchronous) clears parser, escape and line state, empties the
// queue and restores tty_mode = 0, max_payload = 1048576.
module log_stream_demux_ansi_strip_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] char_byte, [39:8] discarded_total
    output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] stream_id
    output logic        m_axis_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = lsdas_pkg::FIFO_AW;
    localparam int CW = lsdas_pkg::FIFO_CW;

    logic        r_tty_mode;
    logic [31:0] r_max_payload;

    logic [2:0]  r_hdr_cnt,     n_hdr_cnt;
    logic [7:0]  r_hdr_stream,  n_hdr_stream;
    logic [31:0] r_hdr_len,     n_hdr_len;
    logic [31:0] r_payload_left, n_payload_left;
    logic [31:0] r_frame_held,  n_frame_held;
    logic        r_frame_stream, n_frame_stream;
    lsdas_pkg::t_esc r_esc,     n_esc;
    logic [31:0] r_esc_held,    n_esc_held;
    logic        r_cr_seen,     n_cr_seen;
    logic        r_line_open,   n_line_open;
    logic        r_line_stream, n_line_stream;
    logic [31:0] r_discard,     n_discard;

    lsdas_pkg::t_res r_mem [lsdas_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic            in_acc, out_acc;
    logic            strip_en, strip_sid, line_en, bad_hdr;
    logic [7:0]      b;
    logic [31:0]     hdr_len_new, esc_add, frm_add;
    logic [33:0]     disc_sum;
    lsdas_pkg::t_tok tok0, tok1;
    logic [1:0]      tok_cnt;
    lsdas_pkg::t_res head;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_count <= CW'(lsdas_pkg::FIFO_DEPTH - lsdas_pkg::MAX_RES));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign b             = s_axis_tdata;
    assign hdr_len_new   = {r_hdr_len[23:0], b};

    always_comb begin
        n_hdr_cnt      = r_hdr_cnt;
        n_hdr_stream   = r_hdr_stream;
        n_hdr_len      = r_hdr_len;
        n_payload_left = r_payload_left;
        n_frame_held   = r_frame_held;
        n_frame_stream = r_frame_stream;
        n_esc          = r_esc;
        n_esc_held     = r_esc_held;
        n_cr_seen      = r_cr_seen;
        n_line_open    = r_line_open;
        n_line_stream  = r_line_stream;
        tok0           = '0;
        tok1           = '0;
        tok_cnt        = 2'd0;
        strip_en       = 1'b0;
        strip_sid      = 1'b0;
        line_en        = 1'b0;
        bad_hdr        = 1'b0;
        esc_add        = '0;
        frm_add        = '0;

        // frame parsing / flush
        if (in_acc) begin
            if (s_axis_tuser) begin
                if (r_esc != lsdas_pkg::ESC_TEXT) esc_add = r_esc_held;
                if (r_hdr_cnt != 3'd0 || r_payload_left != 32'd0) frm_add = r_frame_held;
                if (r_cr_seen || r_line_open) begin
                    tok0.kind = r_cr_seen ? lsdas_pkg::KIND_EMPTY : lsdas_pkg::KIND_PROV;
                    tok0.sid  = r_line_stream;
                    tok1.kind = lsdas_pkg::KIND_DONE;
                    tok_cnt   = 2'd2;
                end else begin
                    tok0.kind = lsdas_pkg::KIND_DONE;
                    tok_cnt   = 2'd1;
                end
                n_cr_seen      = 1'b0;
                n_line_open    = 1'b0;
                n_esc          = lsdas_pkg::ESC_TEXT;
                n_esc_held     = '0;
                n_hdr_cnt      = '0;
                n_hdr_stream   = '0;
                n_hdr_len      = '0;
                n_payload_left = '0;
                n_frame_held   = '0;
            end else if (r_tty_mode) begin
                strip_en  = 1'b1;
                strip_sid = 1'b0;
            end else if (r_payload_left != 32'd0) begin
                n_payload_left = r_payload_left - 32'd1;
                n_frame_held   = (r_payload_left == 32'd1) ? 32'd0
                                                           : lsdas_pkg::sat_inc(r_frame_held);
                strip_en       = 1'b1;
                strip_sid      = r_frame_stream;
            end else if (r_hdr_cnt != lsdas_pkg::HDR_LAST) begin
                if (r_hdr_cnt == 3'd0) begin
                    n_hdr_stream = b;
                    n_hdr_len    = '0;
                end else if (r_hdr_cnt >= lsdas_pkg::HDR_LEN_FIRST) begin
                    n_hdr_len = hdr_len_new;
                end
                n_hdr_cnt    = r_hdr_cnt + 3'd1;
                n_frame_held = lsdas_pkg::sat_inc(r_frame_held);
            end else begin
                // eighth header byte: judge the header
                n_hdr_cnt    = '0;
                n_hdr_len    = hdr_len_new;
                n_frame_held = '0;
                if ((r_hdr_stream != lsdas_pkg::HDR_STDOUT &&
                     r_hdr_stream != lsdas_pkg::HDR_STDERR) ||
                    hdr_len_new > r_max_payload) begin
                    bad_hdr = 1'b1;
                end else begin
                    n_frame_stream = (r_hdr_stream == lsdas_pkg::HDR_STDERR);
                    n_payload_left = hdr_len_new;
                    n_frame_held   = (hdr_len_new != 32'd0) ? lsdas_pkg::HDR_BYTES : 32'd0;
                end
            end
        end

        // escape stripping
        if (strip_en) begin
            case (r_esc)
                lsdas_pkg::ESC_TEXT: begin
                    if (b == lsdas_pkg::CH_ESC) begin
                        n_esc      = lsdas_pkg::ESC_SEEN;
                        n_esc_held = 32'd1;
                    end else begin
                        line_en = 1'b1;
                    end
                end
                lsdas_pkg::ESC_SEEN: begin
                    if (b == lsdas_pkg::CH_LBRACKET) begin
                        n_esc      = lsdas_pkg::ESC_CSI;
                        n_esc_held = lsdas_pkg::sat_inc(r_esc_held);
                    end else if (b == lsdas_pkg::CH_RBRACKET) begin
                        n_esc      = lsdas_pkg::ESC_OSC;
                        n_esc_held = lsdas_pkg::sat_inc(r_esc_held);
                    end else begin
                        n_esc      = lsdas_pkg::ESC_TEXT;
                        n_esc_held = '0;
                    end
                end
                lsdas_pkg::ESC_CSI: begin
                    if (b >= lsdas_pkg::CSI_FINAL_LO && b <= lsdas_pkg::CSI_FINAL_HI) begin
                        n_esc      = lsdas_pkg::ESC_TEXT;
                        n_esc_held = '0;
                    end else begin
                        n_esc_held = lsdas_pkg::sat_inc(r_esc_held);
                    end
                end
                lsdas_pkg::ESC_OSC, lsdas_pkg::ESC_OSC_ESC: begin
                    if (b == lsdas_pkg::CH_BEL ||
                        (r_esc == lsdas_pkg::ESC_OSC_ESC && b == lsdas_pkg::CH_BSLASH)) begin
                        n_esc      = lsdas_pkg::ESC_TEXT;
                        n_esc_held = '0;
                    end else begin
                        n_esc      = (b == lsdas_pkg::CH_ESC) ? lsdas_pkg::ESC_OSC_ESC
                                                             : lsdas_pkg::ESC_OSC;
                        n_esc_held = lsdas_pkg::sat_inc(r_esc_held);
                    end
                end
                default: begin
                    n_esc      = lsdas_pkg::ESC_TEXT;
                    n_esc_held = '0;
                end
            endcase
        end

        // line assembly
        if (line_en) begin
            if (r_cr_seen) begin
                n_cr_seen = 1'b0;
                if (b == lsdas_pkg::CH_LF) begin
                    tok0.kind   = lsdas_pkg::KIND_LINE;
                    tok0.sid    = r_line_open ? r_line_stream : strip_sid;
                    tok_cnt     = 2'd1;
                    n_line_open = 1'b0;
                end else begin
                    // CR then other byte: previous line becomes provisional
                    if (r_line_open) begin
                        tok0.kind = lsdas_pkg::KIND_PROV;
                        tok0.sid  = r_line_stream;
                        tok_cnt   = 2'd1;
                    end
                    n_line_open   = 1'b1;
                    n_line_stream = strip_sid;
                    if (b == lsdas_pkg::CH_CR) begin
                        n_cr_seen = 1'b1;
                    end else if (r_line_open) begin
                        tok1.kind = lsdas_pkg::KIND_CHAR;
                        tok1.sid  = strip_sid;
                        tok1.chr  = b;
                        tok_cnt   = 2'd2;
                    end else begin
                        tok0.kind = lsdas_pkg::KIND_CHAR;
                        tok0.sid  = strip_sid;
                        tok0.chr  = b;
                        tok_cnt   = 2'd1;
                    end
                end
            end else if (b == lsdas_pkg::CH_LF) begin
                tok0.kind   = lsdas_pkg::KIND_LINE;
                tok0.sid    = r_line_open ? r_line_stream : strip_sid;
                tok_cnt     = 2'd1;
                n_line_open = 1'b0;
            end else if (b == lsdas_pkg::CH_CR) begin
                n_cr_seen = 1'b1;
            end else begin
                if (!r_line_open) begin
                    n_line_open   = 1'b1;
                    n_line_stream = strip_sid;
                end
                tok0.kind = lsdas_pkg::KIND_CHAR;
                tok0.sid  = strip_sid;
                tok0.chr  = b;
                tok_cnt   = 2'd1;
            end
        end

        // one saturating sum covers escape, frame and bad-header discards
        disc_sum  = {2'b00, r_discard} + {2'b00, esc_add} + {2'b00, frm_add}
                  + (bad_hdr ? {2'b00, lsdas_pkg::HDR_BYTES} : 34'd0);
        n_discard = (disc_sum[33:32] != 2'b00) ? lsdas_pkg::SAT32 : disc_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tty_mode     <= 1'b0;
            r_max_payload  <= lsdas_pkg::MAX_PAYLOAD_RST;
            r_hdr_cnt      <= '0;
            r_hdr_stream   <= '0;
            r_hdr_len      <= '0;
            r_payload_left <= '0;
            r_frame_held   <= '0;
            r_frame_stream <= 1'b0;
            r_esc          <= lsdas_pkg::ESC_TEXT;
            r_esc_held     <= '0;
            r_cr_seen      <= 1'b0;
            r_line_open    <= 1'b0;
            r_line_stream  <= 1'b0;
            r_discard      <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lsdas_pkg::CFG_TTY_MODE:    r_tty_mode    <= i_cfg_data[0];
                    lsdas_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                    default: ;
                endcase
            end
            r_hdr_cnt      <= n_hdr_cnt;
            r_hdr_stream   <= n_hdr_stream;
            r_hdr_len      <= n_hdr_len;
            r_payload_left <= n_payload_left;
            r_frame_held   <= n_frame_held;
            r_frame_stream <= n_frame_stream;
            r_esc          <= n_esc;
            r_esc_held     <= n_esc_held;
            r_cr_seen      <= n_cr_seen;
            r_line_open    <= n_line_open;
            r_line_stream  <= n_line_stream;
            r_discard      <= n_discard;
            r_wr_ptr       <= r_wr_ptr + AW'(tok_cnt);
            if (out_acc) r_rd_ptr <= r_rd_ptr + AW'(1);
            r_count        <= r_count + CW'(tok_cnt) - CW'(out_acc);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (tok_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= '{tok: tok0, total: n_discard, last: (tok_cnt == 2'd1)};
        end
        if (tok_cnt == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= '{tok: tok1, total: n_discard, last: 1'b1};
        end
    end

    assign head          = r_mem[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {head.total, head.tok.chr};
    assign m_axis_tuser  = {head.tok.sid, head.tok.kind};
    assign m_axis_tlast  = head.last;

endmodule

FILE: src/lsdas_checker.sv
// Port-level checks for log_stream_demux_ansi_strip_core, bound into that module.
// Depends on lsdas_pkg and log_stream_demux_ansi_strip_core_defines.svh.
`include "log_stream_demux_ansi_strip_core_defines.svh"

module lsdas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result word holds
    `LSDAS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

    `LSDAS_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[2:0] <= lsdas_pkg::KIND_DONE, "token kind out of range")

    // flush done always closes the word's results and carries no stream or char
    `LSDAS_ASSERT_IMP(a_done_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2:0] == lsdas_pkg::KIND_DONE, m_axis_tlast && !m_axis_tuser[3] && m_axis_tdata[7:0] == 8'd0, "flush done token malformed")

    `LSDAS_ASSERT_IMP(a_nonchar_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2:0] != lsdas_pkg::KIND_CHAR, m_axis_tdata[7:0] == 8'd0, "non-char token carries a byte")

endmodule

bind log_stream_demux_ansi_strip_core lsdas_checker u_lsdas_checker (.*);
